// File: design/cxy_mcb_pkg.sv
package cxy_mcb_pkg;

    localparam int QUEUE_SLOTS = 20;
    localparam int SLOT_W      = 5;
    localparam int DELTA_W     = 30;
    localparam int TICK_W      = 32;
    localparam int MAG_W       = DELTA_W + 1;
    localparam int CNT_W       = $clog2(TICK_W);
    localparam int DIR_W       = 2;
    localparam int EN_W        = 3;
    localparam int CODE_W      = 3;

    localparam int IN_FIELDS_W  = 2 * DELTA_W + TICK_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SLOT_W + 4 * TICK_W + DIR_W + EN_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [SLOT_W-1:0] SLOT_WRAP_AT  = SLOT_W'(QUEUE_SLOTS - 2);
    localparam logic [CNT_W-1:0]  DIV_LAST      = CNT_W'(TICK_W - 1);

    localparam logic [EN_W-1:0]   ENABLE_MOVE   = 3'h4;
    localparam logic [TICK_W-1:0] STOP_DURATION = 32'd200;
    localparam logic [CODE_W-1:0] CODE_STOP     = 3'h1;
    localparam logic [CODE_W-1:0] CODE_WRAP     = 3'h4;
    localparam logic [DIR_W-1:0]  DIR_A         = 2'h1;
    localparam logic [DIR_W-1:0]  DIR_B         = 2'h2;

    localparam logic OP_MOVE = 1'b0;
    localparam logic OP_STOP = 1'b1;

endpackage

// File: design/corexy_move_command_builder.sv
// CoreXY move command builder. Each input item (a relative timed move or a
// stop, selected by s_axis_tuser) yields one queue command on the master side,
// carrying its ring slot, the half-step periods of motors A (y+x) and B (y-x),
// the Z period (ticks+1, wrapping), end tick, direction, enable and command
// code. A move takes the item, runs the two period divisions one after the
// other on the single shared radix-2 restoring divider (one quotient bit a
// cycle), and loads the output register once it is free. A stop skips the
// divisions. The input side is ready only while no item is in work;
// a finished command may wait in the output register while the next item is
// taken. Slots run from 0 to QUEUE_SLOTS-2; the command in the last one
// carries the wrap flag and the following command goes to slot 0.
module corexy_move_command_builder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // x_delta[29:0], y_delta[59:30], duration_ticks[91:60], zero pad
    input  logic [cxy_mcb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // opcode[0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // slot_index[4:0], motor_a_period[36:5], motor_b_period[68:37],
    // z_axis_period[100:69], cmd_duration[132:101], direction_bits[134:133],
    // enable_bits[137:135], zero pad
    output logic [cxy_mcb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // command_code[2:0]
    output logic [cxy_mcb_pkg::CODE_W-1:0]     m_axis_tuser
);
    import cxy_mcb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_A,
        S_DIV_B,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [SLOT_W-1:0]   r_next_slot;
    logic [SLOT_W-1:0]   r_slot;
    logic [CODE_W-1:0]   r_code;
    logic                r_stop;
    logic [TICK_W-1:0]   r_ticks;
    logic [MAG_W-1:0]    r_mag_a;
    logic [MAG_W-1:0]    r_mag_b;
    logic [DIR_W-1:0]    r_dir;
    logic [TICK_W-1:0]   r_per_a;
    logic [TICK_W-1:0]   r_per_b;
    logic [TICK_W-1:0]   r_quo;
    logic [TICK_W-1:0]   r_rem;
    logic [TICK_W-1:0]   r_dvs;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [CODE_W-1:0]   r_m_user;

    logic signed [DELTA_W-1:0] n_x;
    logic signed [DELTA_W-1:0] n_y;
    logic signed [MAG_W-1:0]   n_a;
    logic signed [MAG_W-1:0]   n_b;
    logic [MAG_W-1:0]          n_mag_a;
    logic [MAG_W-1:0]          n_mag_b;
    logic                      n_wrap;
    logic [TICK_W:0]           n_shift;
    logic                      n_fits;
    logic [TICK_W-1:0]         n_rem;
    logic [TICK_W-1:0]         n_quo;
    logic [TICK_W-1:0]         n_ticks_inc;
    logic                      n_out_free;

    assign n_x     = s_axis_tdata[DELTA_W-1:0];
    assign n_y     = s_axis_tdata[2*DELTA_W-1:DELTA_W];
    assign n_a     = MAG_W'(n_y) + MAG_W'(n_x);
    assign n_b     = MAG_W'(n_y) - MAG_W'(n_x);
    assign n_mag_a = n_a[MAG_W-1] ? MAG_W'(-n_a) : MAG_W'(n_a);
    assign n_mag_b = n_b[MAG_W-1] ? MAG_W'(-n_b) : MAG_W'(n_b);
    assign n_wrap  = (r_next_slot >= SLOT_WRAP_AT);

    assign n_shift     = {r_rem, r_quo[TICK_W-1]};
    assign n_fits      = (n_shift >= {1'b0, r_dvs});
    assign n_rem       = n_fits ? TICK_W'(n_shift - {1'b0, r_dvs}) : n_shift[TICK_W-1:0];
    assign n_quo       = {r_quo[TICK_W-2:0], n_fits};
    assign n_ticks_inc = r_ticks + TICK_W'(1);
    assign n_out_free  = !r_m_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_slot <= '0;
            r_m_valid   <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_slot      <= r_next_slot;
                        r_code      <= n_wrap ? CODE_WRAP : '0;
                        r_next_slot <= n_wrap ? '0 : r_next_slot + SLOT_W'(1);
                        r_stop      <= (s_axis_tuser == OP_STOP);
                        r_ticks     <= s_axis_tdata[IN_FIELDS_W-1:2*DELTA_W];
                        r_mag_a     <= n_mag_a;
                        r_mag_b     <= n_mag_b;
                        r_dir       <= (n_a[MAG_W-1] ? '0 : DIR_A) |
                                       (n_b[MAG_W-1] ? DIR_B : '0);
                        r_quo       <= s_axis_tdata[IN_FIELDS_W-1:2*DELTA_W];
                        r_rem       <= '0;
                        r_dvs       <= {n_mag_a, 1'b0};
                        r_cnt       <= '0;
                        r_state     <= (s_axis_tuser == OP_STOP) ? S_DONE : S_DIV_A;
                    end
                end
                S_DIV_A: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == DIV_LAST) begin
                        r_per_a <= (r_mag_a == '0) ? n_ticks_inc : n_quo;
                        r_quo   <= r_ticks;
                        r_rem   <= '0;
                        r_dvs   <= {r_mag_b, 1'b0};
                        r_cnt   <= '0;
                        r_state <= S_DIV_B;
                    end
                end
                S_DIV_B: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == DIV_LAST) begin
                        r_per_b <= (r_mag_b == '0) ? n_ticks_inc : n_quo;
                        r_cnt   <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (n_out_free) begin
                        r_m_valid <= 1'b1;
                        if (r_stop) begin
                            r_m_data <= OUT_DATA_W'({ {EN_W{1'b0}}, {DIR_W{1'b0}},
                                                      STOP_DURATION, {TICK_W{1'b0}},
                                                      {TICK_W{1'b0}}, {TICK_W{1'b0}},
                                                      r_slot });
                            r_m_user <= r_code | CODE_STOP;
                        end else begin
                            r_m_data <= OUT_DATA_W'({ ENABLE_MOVE, r_dir, r_ticks,
                                                      n_ticks_inc, r_per_b, r_per_a,
                                                      r_slot });
                            r_m_user <= r_code;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input side ready right after taking an item");

    a_slot_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[SLOT_W-1:0] <= SLOT_WRAP_AT))
        else $error("slot index beyond the ring");

    a_wrap_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tuser[2] == 1'b1) ==
                           (m_axis_tdata[SLOT_W-1:0] == SLOT_WRAP_AT)))
        else $error("wrap flag disagrees with slot index");

    a_stop_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[SLOT_W+3*TICK_W-1:SLOT_W] == '0) &&
            (m_axis_tdata[OUT_FIELDS_W-1:SLOT_W+4*TICK_W] == '0))
        else $error("stop command carries non-zero periods or enables");
`endif

endmodule
